// File: rtl/core/rlos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlos_pkg;

	// nesting depth counter width
	localparam int DEPTH_BITS = 8;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX  = {DEPTH_BITS{1'b1}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_ZERO = '0;
	localparam logic [DEPTH_BITS-1:0] DEPTH_ONE  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

	// pattern characters
	localparam logic [7:0] CH_BSL  = 8'h5C; // backslash
	localparam logic [7:0] CH_LBRC = 8'h7B; // {
	localparam logic [7:0] CH_RBRC = 8'h7D; // }
	localparam logic [7:0] CH_QUES = 8'h3F; // ?
	localparam logic [7:0] CH_STAR = 8'h2A; // *
	localparam logic [7:0] CH_PLUS = 8'h2B; // +
	localparam logic [7:0] CH_BAR  = 8'h7C; // |
	localparam logic [7:0] CH_LPAR = 8'h28; // (
	localparam logic [7:0] CH_RPAR = 8'h29; // )
	localparam logic [7:0] CH_LBRK = 8'h5B; // [
	localparam logic [7:0] CH_RBRK = 8'h5D; // ]
	localparam logic [7:0] CH_NONE = 8'h00; // no lookahead

	// governing operator codes
	localparam logic [2:0] OP_END  = 3'd0;
	localparam logic [2:0] OP_FREE = 3'd1;
	localparam logic [2:0] OP_ALT  = 3'd2;
	localparam logic [2:0] OP_PLUS = 3'd3;
	localparam logic [2:0] OP_STAR = 3'd4;
	localparam logic [2:0] OP_QUES = 3'd5;
	localparam logic [2:0] OP_LBRC = 3'd6;
	localparam logic [2:0] OP_RBRC = 3'd7;

	localparam logic [1:0] TALLY_MAX = 2'd2;

	typedef struct packed {
		logic [7:0]            held_char;
		logic                  held_valid;
		logic                  escape_pending;
		logic                  in_bracket_class;
		logic                  in_char_run;
		logic [DEPTH_BITS-1:0] nest_depth;
		logic [1:0]            group_tally;
		logic                  skipping_repeat;
		logic                  decided;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '0;

	typedef struct packed {
		scan_state_t st;
		logic        has_code;
		logic [2:0]  code;
		logic        skip;
	} judge_res_t;

	function automatic logic is_post_op(input logic [7:0] c);
		return (c == CH_LBRC) || (c == CH_RBRC) || (c == CH_QUES) ||
			(c == CH_STAR) || (c == CH_PLUS);
	endfunction

	function automatic logic [1:0] bump_tally(input logic [1:0] t);
		return (t < TALLY_MAX) ? t + 2'd1 : t;
	endfunction

	function automatic logic [2:0] post_op_code(input logic [7:0] c, input logic [1:0] t);
		logic [2:0] r;
		if (t > 2'd1) begin
			r = OP_FREE;
		end else begin
			case (c)
				CH_PLUS: r = OP_PLUS;
				CH_STAR: r = OP_STAR;
				CH_QUES: r = OP_QUES;
				CH_LBRC: r = OP_LBRC;
				default: r = OP_RBRC;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/rlos_judge.sv
`timescale 1ns / 1ps
`default_nettype none

// Judges one character against one character of lookahead.
module rlos_judge (
	input  rlos_pkg::scan_state_t st,
	input  logic [7:0]            ch,
	input  logic [7:0]            nx,
	output rlos_pkg::judge_res_t  res
);

	logic stop;

	always_comb begin
		res          = '0;
		res.st       = st;
		res.code     = rlos_pkg::OP_END;
		stop         = 1'b0;
		if (ch == rlos_pkg::CH_BSL) begin
			res.st.escape_pending = !st.escape_pending;
			stop = !st.escape_pending;
		end
		if (!stop) begin
			if (res.st.escape_pending) begin
				res.st.escape_pending = 1'b0;
				if (st.nest_depth == rlos_pkg::DEPTH_ZERO) begin
					if (!st.in_char_run) begin
						res.st.in_char_run = 1'b1;
						res.st.group_tally = rlos_pkg::bump_tally(st.group_tally);
					end else if (rlos_pkg::is_post_op(nx)) begin
						res.st.group_tally = rlos_pkg::bump_tally(st.group_tally);
						res.skip = (nx == rlos_pkg::CH_LBRC);
					end
				end
			end else if (st.in_bracket_class) begin
				if (ch == rlos_pkg::CH_RBRK) begin
					res.st.in_bracket_class = 1'b0;
					if (rlos_pkg::is_post_op(nx)) begin
						res.st.group_tally = rlos_pkg::bump_tally(st.group_tally);
						res.skip = (nx == rlos_pkg::CH_LBRC);
					end
				end
			end else if (ch == rlos_pkg::CH_LBRK) begin
				res.st.in_bracket_class = 1'b1;
			end else if (st.nest_depth != rlos_pkg::DEPTH_ZERO) begin
				if (ch == rlos_pkg::CH_RPAR) begin
					res.st.nest_depth = st.nest_depth - rlos_pkg::DEPTH_ONE;
					if (st.nest_depth == rlos_pkg::DEPTH_ONE)
						res.st.group_tally = rlos_pkg::bump_tally(st.group_tally);
				end else if (ch == rlos_pkg::CH_LPAR) begin
					if (st.nest_depth < rlos_pkg::DEPTH_MAX)
						res.st.nest_depth = st.nest_depth + rlos_pkg::DEPTH_ONE;
				end
			end else if (ch == rlos_pkg::CH_RPAR) begin
				// stray close paren at top level: ignored
				res.has_code = 1'b0;
			end else if (ch == rlos_pkg::CH_LPAR) begin
				res.st.nest_depth  = rlos_pkg::DEPTH_ONE;
				res.st.in_char_run = 1'b0;
			end else if (ch == rlos_pkg::CH_BAR) begin
				res.has_code = 1'b1;
				res.code     = rlos_pkg::OP_ALT;
			end else if (rlos_pkg::is_post_op(ch)) begin
				res.has_code = 1'b1;
				res.code     = rlos_pkg::post_op_code(ch, st.group_tally);
			end else if (!st.in_char_run) begin
				res.st.in_char_run = 1'b1;
				res.st.group_tally = rlos_pkg::bump_tally(st.group_tally);
			end else if (rlos_pkg::is_post_op(nx)) begin
				res.st.group_tally = rlos_pkg::bump_tally(st.group_tally);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rlos_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One full scan step: held character judged with the new one as lookahead,
// then at the last mark the new character judged with no lookahead.
module rlos_step (
	input  rlos_pkg::scan_state_t st,
	input  logic [7:0]            symbol,
	input  logic                  last,
	output rlos_pkg::scan_state_t st_next,
	output logic                  emit,
	output logic [2:0]            emit_op
);

	rlos_pkg::judge_res_t  j1_res;
	rlos_pkg::judge_res_t  j2_res;
	rlos_pkg::scan_state_t st_a;
	logic                  has_a;
	logic [2:0]            code_a;
	logic                  run_j2;

	rlos_judge u_judge_look (
		.st  (st),
		.ch  (st.held_char),
		.nx  (symbol),
		.res (j1_res)
	);

	// state after the lookahead judgment and character hand-over
	always_comb begin
		st_a   = st;
		has_a  = 1'b0;
		code_a = rlos_pkg::OP_END;
		if (!st.decided) begin
			if (st.skipping_repeat) begin
				if (symbol == rlos_pkg::CH_RBRC) begin
					st_a.skipping_repeat = 1'b0;
					st_a.held_char       = symbol;
					st_a.held_valid      = 1'b1;
				end
			end else begin
				if (st.held_valid) begin
					st_a   = j1_res.st;
					has_a  = j1_res.has_code;
					code_a = j1_res.code;
				end
				if (!has_a && st.held_valid && j1_res.skip) begin
					st_a.skipping_repeat = 1'b1;
					st_a.held_valid      = 1'b0;
				end else begin
					st_a.held_char  = symbol;
					st_a.held_valid = 1'b1;
				end
			end
		end
	end

	rlos_judge u_judge_tail (
		.st  (st_a),
		.ch  (st_a.held_char),
		.nx  (rlos_pkg::CH_NONE),
		.res (j2_res)
	);

	assign run_j2 = !has_a && st_a.held_valid && !st_a.skipping_repeat;

	always_comb begin
		st_next = st_a;
		emit    = 1'b0;
		emit_op = code_a;
		if (st.decided) begin
			if (last)
				st_next = rlos_pkg::STATE_RESET;
		end else if (last) begin
			emit = 1'b1;
			if (!has_a) begin
				if (run_j2 && j2_res.has_code)
					emit_op = j2_res.code;
				else if (run_j2)
					emit_op = (j2_res.st.group_tally > 2'd1) ?
						rlos_pkg::OP_FREE : rlos_pkg::OP_END;
				else
					emit_op = (st_a.group_tally > 2'd1) ?
						rlos_pkg::OP_FREE : rlos_pkg::OP_END;
			end
			st_next = rlos_pkg::STATE_RESET;
		end else if (has_a) begin
			emit            = 1'b1;
			st_next.decided = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/regex_leading_operator_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Leading-operator scan of a regex pattern.
// Input stream: one pattern character per item on s_tdata, s_tlast set on
// the final character. Output stream: exactly one item per pattern on
// m_tdata[2:0], the governing operator code (0 end-bound, 1 free,
// 2 alternation, 3 plus, 4 star, 5 question, 6 open brace, 7 close brace).
// The code goes out as soon as it is known, or with the last character;
// later characters of a decided pattern are consumed without output.
// Each item is registered at the input, judged, and registered again in the
// result register that drives m_tvalid. Throughput: one item per cycle unless
// a waiting result is held by m_tready; the per-character judgment is a short
// chain of compares and flag updates between the input and result register.
// When m_tready is low with a result waiting, the judging stage holds and
// s_tready stays high until the input register is full as well.
// Reset (arst_n low) clears the scan state, so the block starts a new
// pattern; scan state also returns to reset after each last character.
module regex_leading_operator_scan_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,  // [7:0] symbol
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata   // [2:0] governing_op, [7:3] zero
);

	logic                  valid_s1;
	logic [7:0]            symbol_s1;
	logic                  last_s1;
	logic                  advance;
	rlos_pkg::scan_state_t state_q;
	rlos_pkg::scan_state_t state_next;
	logic                  emit;
	logic [2:0]            emit_op;
	logic                  out_valid_q;
	logic [2:0]            out_op_q;

	// the judging stage moves whenever it holds an item and the result register is empty or being read
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			symbol_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	rlos_step u_step (
		.st      (state_q),
		.symbol  (symbol_s1),
		.last    (last_s1),
		.st_next (state_next),
		.emit    (emit),
		.emit_op (emit_op)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlos_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_next;
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_op_q <= emit_op;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_op_q};

endmodule

`default_nettype wire
